/* rtl/core/ppns_pkg.sv */
package ppns_pkg;

   // Store geometry
   localparam int MAX_ATOMS  = 64;
   localparam int COORD_BITS = 32;
   localparam int STORE_BITS = (COORD_BITS < 32) ? COORD_BITS : 32;
   localparam int ADDR_BITS  = $clog2(MAX_ATOMS);

   // Field widths fixed by the interface
   localparam int INDEX_BITS = 6;
   localparam int CNT_BITS   = 7;
   localparam int POS_BITS   = 32;
   localparam int DELTA_BITS = 34;
   localparam int LEN_BITS   = 31;
   localparam int CSR_BITS   = 3;
   localparam int WDATA_BITS = 31;
   localparam int WRAP_BITS  = DELTA_BITS + 2;
   localparam int MAG_BITS   = 31;
   localparam int SQ_BITS    = 2 * MAG_BITS;
   localparam int SUM_BITS   = SQ_BITS + 2;
   localparam int NUM_AXES   = 3;

   // Atom index range and the resulting cap on the count
   localparam int INDEX_SPAN    = 1 << INDEX_BITS;
   localparam int LIMIT_CAP_INT = (MAX_ATOMS < INDEX_SPAN) ? MAX_ATOMS : INDEX_SPAN;
   localparam logic [CNT_BITS-1:0] LIMIT_CAP = CNT_BITS'(LIMIT_CAP_INT);

   // Operation codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   // Register indexes
   typedef enum logic [CSR_BITS-1:0] {
      REG_ATOM_COUNT    = 3'd0,
      REG_PERIODIC_MODE = 3'd1,
      REG_BOX_X         = 3'd2,
      REG_BOX_Y         = 3'd3,
      REG_BOX_Z         = 3'd4,
      REG_CUTOFF        = 3'd5
   } csr_reg_type;

   // Controller to datapath
   typedef struct packed {
      logic load_we;   // write the position stores
      logic capture;   // latch atom i of a search
      logic rd_base;   // read address from atom i, else from j
      logic init_j;    // latch pos[i], set j to i+1
      logic issue;     // read pos[j] into the pipe, advance j
      logic token;     // push the end-of-search marker
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic more;      // j is still below the limit
      logic drained;   // end marker has reached the output stage
   } dp_status_type;

endpackage

/* rtl/core/ppns_ram.sv */
module ppns_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ppns_ctrl.sv */
module ppns_ctrl import ppns_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic          req_opcode,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_BASE  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_DRAIN = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.load_we = accept && (req_opcode == OP_LOAD);
      cmd.capture = accept && (req_opcode == OP_SEARCH);
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.capture) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.rd_base = 1'b1;
            state_in    = ST_BASE;
         end
         ST_BASE: begin
            cmd.init_j = 1'b1;
            state_in   = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.more) begin
               cmd.issue = 1'b1;
            end else begin
               cmd.token = 1'b1;
               state_in  = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.drained) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/ppns_datapath.sv */
module ppns_datapath import ppns_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   input  dp_cmd_type                   cmd,
   output dp_status_type                status,
   input  logic [INDEX_BITS-1:0]        req_atom_index,
   input  logic signed [POS_BITS-1:0]   req_pos_x,
   input  logic signed [POS_BITS-1:0]   req_pos_y,
   input  logic signed [POS_BITS-1:0]   req_pos_z,
   input  logic                         csr_wr,
   input  logic [CSR_BITS-1:0]          csr_index,
   input  logic [WDATA_BITS-1:0]        csr_wdata,
   output logic                         rsp_valid,
   output logic [INDEX_BITS-1:0]        rsp_first_atom,
   output logic [INDEX_BITS-1:0]        rsp_second_atom,
   output logic signed [DELTA_BITS-1:0] rsp_delta_x,
   output logic signed [DELTA_BITS-1:0] rsp_delta_y,
   output logic signed [DELTA_BITS-1:0] rsp_delta_z,
   output logic                         rsp_found,
   output logic                         rsp_last
);

   typedef logic signed [DELTA_BITS-1:0] delta_type;
   typedef logic signed [WRAP_BITS-1:0]  wide_type;

   typedef struct packed {
      logic                  v;
      logic                  tok;
      logic [INDEX_BITS-1:0] j;
   } tag_type;

   // Minimum image, first half: pull a component above half the box down
   function automatic delta_type wrap_down(input delta_type d, input logic [LEN_BITS-1:0] len);
      wide_type  twice;
      wide_type  lim;
      delta_type len_d;
      twice = {d[DELTA_BITS-1], d, 1'b0};
      lim   = $signed({{(WRAP_BITS-LEN_BITS){1'b0}}, len});
      len_d = $signed({{(DELTA_BITS-LEN_BITS){1'b0}}, len});
      return (twice > lim) ? (d - len_d) : d;
   endfunction

   // Minimum image, second half: push a component below minus half the box up
   function automatic delta_type wrap_up(input delta_type d, input logic [LEN_BITS-1:0] len);
      wide_type  twice;
      wide_type  lim;
      delta_type len_d;
      twice = {d[DELTA_BITS-1], d, 1'b0};
      lim   = $signed({{(WRAP_BITS-LEN_BITS){1'b0}}, len});
      len_d = $signed({{(DELTA_BITS-LEN_BITS){1'b0}}, len});
      return (twice < -lim) ? (d + len_d) : d;
   endfunction

   // Configuration
   logic [CNT_BITS-1:0] count_ff;
   logic                periodic_ff;
   logic [LEN_BITS-1:0] box_ff [NUM_AXES];
   logic [LEN_BITS-1:0] cutoff_ff;
   logic [CNT_BITS-1:0] limit_ff;
   logic [SQ_BITS-1:0]  cut2_ff;

   // Search control
   logic [INDEX_BITS-1:0] idx_ff;
   logic [CNT_BITS-1:0]   j_ff;

   // Position stores
   logic                  wr_en;
   logic [ADDR_BITS-1:0]  wr_addr;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [STORE_BITS-1:0] wr_pos  [NUM_AXES];
   logic [STORE_BITS-1:0] rd_pos  [NUM_AXES];
   logic [STORE_BITS-1:0] base_ff [NUM_AXES];

   // Pipeline
   tag_type              s0_tag_ff, s1_tag_ff, s2_tag_ff, s3_tag_ff;
   tag_type              s4_tag_ff, s5_tag_ff, s6_tag_ff;
   delta_type            s1_d_ff [NUM_AXES];
   delta_type            s2_d_ff [NUM_AXES];
   delta_type            s3_d_ff [NUM_AXES];
   delta_type            s4_d_ff [NUM_AXES];
   delta_type            s5_d_ff [NUM_AXES];
   delta_type            s6_d_ff [NUM_AXES];
   logic [MAG_BITS-1:0]  s4_mag_ff [NUM_AXES];
   logic [SQ_BITS-1:0]   s5_sq_ff  [NUM_AXES];
   logic                 s4_near_ff, s5_near_ff, s6_near_ff;
   logic [SUM_BITS-1:0]  s6_sum_ff;
   logic                 hit;

   // Pending pair and result registers
   logic                  pend_v_ff, pend_v_in;
   logic [INDEX_BITS-1:0] pend_j_ff;
   delta_type             pend_d_ff [NUM_AXES];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [INDEX_BITS-1:0] rsp_first_ff;
   logic [INDEX_BITS-1:0] rsp_second_ff, rsp_second_in;
   delta_type             rsp_d_ff [NUM_AXES];
   delta_type             rsp_d_in [NUM_AXES];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         periodic_ff <= 1'b1;
         cutoff_ff   <= '0;
         for (int a = 0; a < NUM_AXES; a++) begin
            box_ff[a] <= '0;
         end
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_ATOM_COUNT:    count_ff    <= csr_wdata[CNT_BITS-1:0];
            REG_PERIODIC_MODE: periodic_ff <= csr_wdata[0];
            REG_BOX_X:         box_ff[0]   <= csr_wdata[LEN_BITS-1:0];
            REG_BOX_Y:         box_ff[1]   <= csr_wdata[LEN_BITS-1:0];
            REG_BOX_Z:         box_ff[2]   <= csr_wdata[LEN_BITS-1:0];
            REG_CUTOFF:        cutoff_ff   <= csr_wdata[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Derived settings, stable while idle
   always_ff @(posedge clock) begin
      limit_ff <= (count_ff > LIMIT_CAP) ? LIMIT_CAP : count_ff;
      cut2_ff  <= cutoff_ff * cutoff_ff;
   end

   // Stores: drop loads beyond the store
   assign wr_en     = cmd.load_we && (32'(req_atom_index) < MAX_ATOMS);
   assign wr_addr   = ADDR_BITS'(req_atom_index);
   assign wr_pos[0] = req_pos_x[STORE_BITS-1:0];
   assign wr_pos[1] = req_pos_y[STORE_BITS-1:0];
   assign wr_pos[2] = req_pos_z[STORE_BITS-1:0];
   assign rd_addr   = cmd.rd_base ? ADDR_BITS'(idx_ff) : ADDR_BITS'(j_ff);

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_store
      ppns_ram #(
         .WIDTH (STORE_BITS),
         .DEPTH (MAX_ATOMS)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (wr_pos[g]),
         .rd_addr (rd_addr),
         .rd_data (rd_pos[g])
      );
   end

   // Search index, base position and j counter
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff <= req_atom_index;
      end
      if (cmd.init_j) begin
         j_ff <= CNT_BITS'(idx_ff) + CNT_BITS'(1);
         for (int a = 0; a < NUM_AXES; a++) begin
            base_ff[a] <= rd_pos[a];
         end
      end else if (cmd.issue) begin
         j_ff <= j_ff + CNT_BITS'(1);
      end
   end

   assign status.more    = (j_ff < limit_ff);
   assign status.drained = s6_tag_ff.tok;

   // Tags: control state of the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_tag_ff <= '0;
         s1_tag_ff <= '0;
         s2_tag_ff <= '0;
         s3_tag_ff <= '0;
         s4_tag_ff <= '0;
         s5_tag_ff <= '0;
         s6_tag_ff <= '0;
      end else begin
         s0_tag_ff.v   <= cmd.issue;
         s0_tag_ff.tok <= cmd.token;
         s0_tag_ff.j   <= j_ff[INDEX_BITS-1:0];
         s1_tag_ff     <= s0_tag_ff;
         s2_tag_ff     <= s1_tag_ff;
         s3_tag_ff     <= s2_tag_ff;
         s4_tag_ff     <= s3_tag_ff;
         s5_tag_ff     <= s4_tag_ff;
         s6_tag_ff     <= s5_tag_ff;
      end
   end

   // Datapath stages, one lane per axis
   always_ff @(posedge clock) begin
      for (int a = 0; a < NUM_AXES; a++) begin
         s1_d_ff[a] <= delta_type'($signed(rd_pos[a])) - delta_type'($signed(base_ff[a]));
         s2_d_ff[a] <= periodic_ff ? wrap_down(s1_d_ff[a], box_ff[a]) : s1_d_ff[a];
         s3_d_ff[a] <= periodic_ff ? wrap_up(s2_d_ff[a], box_ff[a]) : s2_d_ff[a];
         s4_d_ff[a] <= s3_d_ff[a];
         s5_d_ff[a] <= s4_d_ff[a];
         s6_d_ff[a] <= s5_d_ff[a];
         s5_sq_ff[a] <= s4_mag_ff[a] * s4_mag_ff[a];
      end
      s5_near_ff <= s4_near_ff;
      s6_near_ff <= s5_near_ff;
      s6_sum_ff  <= SUM_BITS'(s5_sq_ff[0]) + SUM_BITS'(s5_sq_ff[1])
                    + SUM_BITS'(s5_sq_ff[2]);
   end

   // Magnitude stage: a component of 2^31 or more rules the pair out
   always_ff @(posedge clock) begin
      logic [DELTA_BITS-1:0] mag;
      logic                  near;
      near = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
         mag = s3_d_ff[a][DELTA_BITS-1] ? DELTA_BITS'(-s3_d_ff[a]) : DELTA_BITS'(s3_d_ff[a]);
         s4_mag_ff[a] <= mag[MAG_BITS-1:0];
         if (mag[DELTA_BITS-1:MAG_BITS] != '0) begin
            near = 1'b0;
         end
      end
      s4_near_ff <= near;
   end

   assign hit = s6_tag_ff.v && s6_near_ff && (s6_sum_ff < SUM_BITS'(cut2_ff));

   // Hold one pair back so the final one can carry the last flag
   always_comb begin
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_found_in  = 1'b0;
      rsp_second_in = pend_j_ff;
      pend_v_in     = pend_v_ff;
      for (int a = 0; a < NUM_AXES; a++) begin
         rsp_d_in[a] = pend_d_ff[a];
      end
      if (s6_tag_ff.tok) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         rsp_found_in = pend_v_ff;
         pend_v_in    = 1'b0;
         if (!pend_v_ff) begin
            rsp_second_in = '0;
            for (int a = 0; a < NUM_AXES; a++) begin
               rsp_d_in[a] = '0;
            end
         end
      end else if (hit) begin
         rsp_valid_in = pend_v_ff;
         rsp_found_in = 1'b1;
         pend_v_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hit) begin
         pend_j_ff <= s6_tag_ff.j;
         for (int a = 0; a < NUM_AXES; a++) begin
            pend_d_ff[a] <= s6_d_ff[a];
         end
      end
      rsp_last_ff   <= rsp_last_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= idx_ff;
      rsp_second_ff <= rsp_second_in;
      for (int a = 0; a < NUM_AXES; a++) begin
         rsp_d_ff[a] <= rsp_d_in[a];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_atom  = rsp_first_ff;
   assign rsp_second_atom = rsp_second_ff;
   assign rsp_delta_x     = rsp_d_ff[0];
   assign rsp_delta_y     = rsp_d_ff[1];
   assign rsp_delta_z     = rsp_d_ff[2];
   assign rsp_found       = rsp_found_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

/* rtl/core/periodic_pair_neighbor_search.sv */
// Load: busy stays low, no result. Search of atom i over n = max(0, limit-i-1)
// atoms: busy throughout, one atom j per cycle through the store read port and a
// 7-stage pipe; one to max(1, n) results, the final one in the first cycle with busy low,
// where the next command may already transfer; searches never stall.
// Synchronous active-high reset clears the controller, pipe and registers (count 0,
// periodic mode on, boxes and cutoff 0); position stores are not cleared.
module periodic_pair_neighbor_search import ppns_pkg::*; (
   input  logic                         clock,
   input  logic                         reset,
   // Command channel
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_opcode,
   input  logic [INDEX_BITS-1:0]        req_atom_index,
   input  logic signed [POS_BITS-1:0]   req_pos_x,
   input  logic signed [POS_BITS-1:0]   req_pos_y,
   input  logic signed [POS_BITS-1:0]   req_pos_z,
   // Result channel
   output logic                         rsp_valid,
   output logic [INDEX_BITS-1:0]        rsp_first_atom,
   output logic [INDEX_BITS-1:0]        rsp_second_atom,
   output logic signed [DELTA_BITS-1:0] rsp_delta_x,
   output logic signed [DELTA_BITS-1:0] rsp_delta_y,
   output logic signed [DELTA_BITS-1:0] rsp_delta_z,
   output logic                         rsp_found,
   output logic                         rsp_last,
   // Register write channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_BITS-1:0]          csr_index,
   input  logic [WDATA_BITS-1:0]        csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   // Registers are plain flops, so every write transfer is taken at once.
   // Writes to indexes beyond the register list are dropped in the datapath.
   assign csr_ready = 1'b1;

   // Controller: sequences a search as fetch of atom i, latch of its position,
   // a scan issuing one j per cycle, then an end marker and a drain of the pipe.
   // Loads go straight to the stores in the transfer cycle.
   ppns_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy)
   );

   // Datapath: three per-axis position stores, the displacement and
   // minimum-image stages, squaring, the cutoff compare, and a one-deep
   // holding register that lets the final pair of a search carry the last flag.
   ppns_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_atom_index  (req_atom_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .csr_wr          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_first_atom  (rsp_first_atom),
      .rsp_second_atom (rsp_second_atom),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_delta_z     (rsp_delta_z),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last)
   );

endmodule

/* rtl/core/ppns_checker.sv */
module ppns_checker import ppns_pkg::*; (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic                         req_opcode,
   input logic                         rsp_valid,
   input logic [INDEX_BITS-1:0]        rsp_first_atom,
   input logic [INDEX_BITS-1:0]        rsp_second_atom,
   input logic signed [DELTA_BITS-1:0] rsp_delta_x,
   input logic signed [DELTA_BITS-1:0] rsp_delta_y,
   input logic signed [DELTA_BITS-1:0] rsp_delta_z,
   input logic                         rsp_found,
   input logic                         rsp_last
);

   // A search with no pair gives one empty, final result
   a_empty_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_last && (rsp_second_atom == '0)
         && (rsp_delta_x == '0) && (rsp_delta_y == '0) && (rsp_delta_z == '0))
      else $error("empty search result not final or not cleared");

   // Pairs always run upwards from atom i
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_second_atom > rsp_first_atom)
      else $error("pair index not above searched atom");

   // More results still to come, so the block must still be busy
   a_busy_until_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("non-final result while idle");

   // A load transfer leaves the block idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_LOAD) |=> !busy && !rsp_valid)
      else $error("load transfer did not leave block idle");

   // A search transfer starts a busy period
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == OP_SEARCH) |=> busy)
      else $error("search transfer did not raise busy");

endmodule

bind periodic_pair_neighbor_search ppns_checker u_ppns_checker (.*);

/* verif/tb_top.sv */
module tb_top;
   import ppns_pkg::*;

   // Run limits, in clock cycles
   localparam int RUN_LIMIT     = 400000;
   localparam int SETTLE_CYCLES = 16;

   // Q16.16 helpers for the directed part
   localparam int ONE    = 1 << 16;
   localparam int HALF   = 1 << 15;
   localparam int CENTRE = 2 * ONE;

   // Register indexes past the end of the map; writes there must be dropped
   localparam logic [CSR_BITS-1:0] REG_UNMAPPED_LO = 3'd6;
   localparam logic [CSR_BITS-1:0] REG_UNMAPPED_HI = 3'd7;

   // One pair result as the block should present it
   typedef struct {
      logic [INDEX_BITS-1:0] first_atom;
      logic [INDEX_BITS-1:0] second_atom;
      logic [DELTA_BITS-1:0] delta [NUM_AXES];
      logic                  found;
      logic                  last;
   } pair_result_type;

   // Scoreboard: mirrors the position store and registers, predicts the
   // pairs each search transfer should produce and checks them in order.
   class pair_scoreboard;
      logic signed [POS_BITS-1:0] coord [NUM_AXES][MAX_ATOMS];
      bit                         slot_loaded [MAX_ATOMS];
      logic [CNT_BITS-1:0]        atom_count;
      logic                       periodic;
      logic [LEN_BITS-1:0]        box [NUM_AXES];
      logic [LEN_BITS-1:0]        cutoff;
      pair_result_type            pending [$];
      int                         mismatches;

      function new();
         atom_count = '0;
         periodic   = 1'b1;
         cutoff     = '0;
         mismatches = 0;
         for (int a = 0; a < NUM_AXES; a++) box[a] = '0;
         for (int s = 0; s < MAX_ATOMS; s++) slot_loaded[s] = 1'b0;
      endfunction

      function int search_limit();
         return (atom_count > LIMIT_CAP) ? int'(LIMIT_CAP) : int'(atom_count);
      endfunction

      // First slot a search from atom i would read that is still unwritten, or -1
      function int missing_slot(int i);
         if (!slot_loaded[i]) return i;
         for (int j = i + 1; j < search_limit(); j++)
            if (!slot_loaded[j]) return j;
         return -1;
      endfunction

      function int outstanding();
         return pending.size();
      endfunction

      function void note_register(logic [CSR_BITS-1:0] idx, logic [WDATA_BITS-1:0] data);
         case (idx)
            REG_ATOM_COUNT:    atom_count = data[CNT_BITS-1:0];
            REG_PERIODIC_MODE: periodic   = data[0];
            REG_BOX_X:         box[0]     = data[LEN_BITS-1:0];
            REG_BOX_Y:         box[1]     = data[LEN_BITS-1:0];
            REG_BOX_Z:         box[2]     = data[LEN_BITS-1:0];
            REG_CUTOFF:        cutoff     = data[LEN_BITS-1:0];
            default: ;
         endcase
      endfunction

      // Walk j above i, wrap each axis once, keep pairs strictly inside the cutoff
      function void predict_pairs(int i);
         longint            d [NUM_AXES];
         longint unsigned   mag, dist2, cut2;
         bit                reach;
         int                emitted;
         pair_result_type   r;
         cut2    = longint'(cutoff) * longint'(cutoff);
         emitted = 0;
         for (int j = i + 1; j < search_limit(); j++) begin
            dist2 = 0;
            reach = 1'b1;
            for (int a = 0; a < NUM_AXES; a++) begin
               d[a] = longint'(coord[a][j]) - longint'(coord[a][i]);
               if (periodic) begin
                  if (2 * d[a] > longint'(box[a])) d[a] -= longint'(box[a]);
                  if (2 * d[a] < -longint'(box[a])) d[a] += longint'(box[a]);
               end
               mag = (d[a] < 0) ? -d[a] : d[a];
               // a component this far out can never be inside any cutoff
               if (mag >= (64'd1 << 31)) reach = 1'b0;
               else dist2 += mag * mag;
            end
            if (reach && dist2 < cut2) begin
               r.first_atom  = INDEX_BITS'(i);
               r.second_atom = INDEX_BITS'(j);
               for (int a = 0; a < NUM_AXES; a++) r.delta[a] = d[a][DELTA_BITS-1:0];
               r.found = 1'b1;
               r.last  = 1'b0;
               pending.insert(pending.size(), r);
               emitted++;
            end
         end
         if (emitted == 0) begin
            r.first_atom  = INDEX_BITS'(i);
            r.second_atom = '0;
            for (int a = 0; a < NUM_AXES; a++) r.delta[a] = '0;
            r.found = 1'b0;
            r.last  = 1'b1;
            pending.insert(pending.size(), r);
         end else begin
            r = pending.pop_back();
            r.last = 1'b1;
            pending.insert(pending.size(), r);
         end
      endfunction

      function void note_command(logic op, logic [INDEX_BITS-1:0] idx,
                                 logic signed [POS_BITS-1:0] px,
                                 logic signed [POS_BITS-1:0] py,
                                 logic signed [POS_BITS-1:0] pz);
         if (op == OP_LOAD) begin
            coord[0][idx]    = px;
            coord[1][idx]    = py;
            coord[2][idx]    = pz;
            slot_loaded[idx] = 1'b1;
         end else begin
            predict_pairs(int'(idx));
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("tb_top: mismatch: %s", msg);
      endtask

      task compare_field(string ctx, string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s %s got %0h want %0h", ctx, name, got, want));
      endtask

      task check_result(logic [INDEX_BITS-1:0] first_atom, logic [INDEX_BITS-1:0] second_atom,
                        logic [DELTA_BITS-1:0] dx, logic [DELTA_BITS-1:0] dy,
                        logic [DELTA_BITS-1:0] dz, logic found, logic last);
         pair_result_type e;
         string           ctx;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("result %0d-%0d with nothing pending",
                                      first_atom, second_atom));
            return;
         end
         e   = pending.pop_front();
         ctx = $sformatf("pair %0d-%0d:", e.first_atom, e.second_atom);
         compare_field(ctx, "first_atom", 64'(first_atom), 64'(e.first_atom));
         compare_field(ctx, "second_atom", 64'(second_atom), 64'(e.second_atom));
         compare_field(ctx, "delta_x", 64'(dx), 64'(e.delta[0]));
         compare_field(ctx, "delta_y", 64'(dy), 64'(e.delta[1]));
         compare_field(ctx, "delta_z", 64'(dz), 64'(e.delta[2]));
         compare_field(ctx, "found", 64'(found), 64'(e.found));
         compare_field(ctx, "last", 64'(last), 64'(e.last));
      endtask
   endclass

   // Block ports
   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic                         req_opcode;
   logic [INDEX_BITS-1:0]        req_atom_index;
   logic signed [POS_BITS-1:0]   req_pos_x;
   logic signed [POS_BITS-1:0]   req_pos_y;
   logic signed [POS_BITS-1:0]   req_pos_z;
   logic                         rsp_valid;
   logic [INDEX_BITS-1:0]        rsp_first_atom;
   logic [INDEX_BITS-1:0]        rsp_second_atom;
   logic signed [DELTA_BITS-1:0] rsp_delta_x;
   logic signed [DELTA_BITS-1:0] rsp_delta_y;
   logic signed [DELTA_BITS-1:0] rsp_delta_z;
   logic                         rsp_found;
   logic                         rsp_last;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_BITS-1:0]          csr_index;
   logic [WDATA_BITS-1:0]        csr_wdata;

   pair_scoreboard board = new();
   int unsigned    cycle_count = 0;

   periodic_pair_neighbor_search dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_atom_index  (req_atom_index),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .rsp_valid       (rsp_valid),
      .rsp_first_atom  (rsp_first_atom),
      .rsp_second_atom (rsp_second_atom),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_delta_z     (rsp_delta_z),
      .rsp_found       (rsp_found),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Results cannot be held off: take every strobed one at the edge closing its cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_first_atom, rsp_second_atom, rsp_delta_x, rsp_delta_y,
                            rsp_delta_z, rsp_found, rsp_last);
   end

   // Watchdog: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Present one command at the falling edge and hold it until busy is low at a
   // rising edge; start stays high so a following command goes straight after.
   task automatic send_command(logic op, int idx, int x, int y, int z);
      @(negedge clock);
      start          = 1'b1;
      req_opcode     = op;
      req_atom_index = INDEX_BITS'(idx);
      req_pos_x      = x;
      req_pos_y      = y;
      req_pos_z      = z;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_command(op, INDEX_BITS'(idx), x, y, z);
   endtask

   // Drop start for a number of cycles
   task automatic idle_gap(int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold the command side until every predicted result has arrived, then let
   // the pipe drain; loads leave no trace in the queue, hence the extra cycles.
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_BITS-1:0] idx, int data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = WDATA_BITS'(data);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.note_register(idx, WDATA_BITS'(data));
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Reprogram the whole register set once the block is quiet
   task automatic set_geometry(int count, int mode, int bx, int by, int bz, int cut);
      settle();
      write_register(REG_ATOM_COUNT, count);
      write_register(REG_PERIODIC_MODE, mode);
      write_register(REG_BOX_X, bx);
      write_register(REG_BOX_Y, by);
      write_register(REG_BOX_Z, bz);
      write_register(REG_CUTOFF, cut);
   endtask

   // Coordinate mostly clustered or hugging a box face, sometimes anywhere
   function automatic int coord_near(logic [LEN_BITS-1:0] box, int spread);
      case ($urandom_range(0, 3))
         0:       return CENTRE + int'($urandom_range(0, 2 * spread)) - spread;
         1:       return $urandom_range(0, spread);
         2:       return int'(box) - int'($urandom_range(0, spread));
         default: return $urandom;
      endcase
   endfunction

   // One random transfer: clustered loads and searches over loaded atoms,
   // with some noise. A search that would touch an unwritten slot becomes a
   // load of that slot instead.
   task automatic random_item(int spread);
      int   lim, pick, miss;
      bit   noisy;
      logic op;
      int   idx;
      int   p [NUM_AXES];
      lim   = board.search_limit();
      pick  = $urandom_range(0, 99);
      noisy = (pick < 15);
      if (noisy) begin
         op  = ($urandom_range(0, 1) != 0) ? OP_SEARCH : OP_LOAD;
         idx = $urandom_range(0, INDEX_SPAN - 1);
      end else if (pick < 60) begin
         op  = OP_LOAD;
         idx = (lim > 0) ? $urandom_range(0, lim - 1) : $urandom_range(0, INDEX_SPAN - 1);
      end else begin
         op  = OP_SEARCH;
         idx = (lim > 1 && $urandom_range(0, 7) != 0) ? $urandom_range(0, lim - 2)
                                                      : $urandom_range(0, INDEX_SPAN - 1);
      end
      if (op == OP_SEARCH) begin
         miss = board.missing_slot(idx);
         if (miss >= 0) begin
            op  = OP_LOAD;
            idx = miss;
         end
      end
      for (int a = 0; a < NUM_AXES; a++)
         p[a] = noisy ? int'($urandom) : coord_near(board.box[a], spread);
      send_command(op, idx, p[0], p[1], p[2]);
   endtask

   // Random stretch with a given percentage chance of an idle gap before each item;
   // halfway through, pause until all results are back.
   task automatic run_phase(int items, int idle_pct, int spread);
      for (int k = 0; k < items; k++) begin
         if (k == items / 2) settle();
         if ($urandom_range(0, 99) < idle_pct)
            idle_gap(($urandom_range(0, 9) == 0) ? $urandom_range(30, 90)
                                                 : $urandom_range(1, 12));
         random_item(spread);
      end
   endtask

   initial begin
      // Every input known from time zero
      reset          = 1'b1;
      start          = 1'b0;
      req_opcode     = OP_LOAD;
      req_atom_index = '0;
      req_pos_x      = '0;
      req_pos_y      = '0;
      req_pos_z      = '0;
      csr_valid      = 1'b0;
      csr_index      = REG_ATOM_COUNT;
      csr_wdata      = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset registers: count 0 and cutoff 0, so the search finds nothing
      send_command(OP_LOAD, 0, 32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      send_command(OP_SEARCH, 0, 0, 0, 0);

      // Ten-unit box, cutoff three: wrap down, wrap up and the exact-cutoff pair
      set_geometry(6, 1, 10 * ONE, 10 * ONE, 10 * ONE, 3 * ONE);
      send_command(OP_LOAD, 1, ONE, ONE, ONE);
      send_command(OP_LOAD, 2, 9 * ONE + HALF, ONE + HALF, ONE);
      send_command(OP_LOAD, 3, ONE + HALF, 9 * ONE + 3 * HALF / 2, ONE);
      send_command(OP_LOAD, 4, 4 * ONE, ONE, ONE);
      send_command(OP_LOAD, 5, 5 * ONE, 5 * ONE, 5 * ONE);
      send_command(OP_LOAD, 63, -ONE, -1, ONE);
      send_command(OP_SEARCH, 1, 0, 0, 0);
      send_command(OP_SEARCH, 2, 0, 0, 0);
      // atom 0 sits at the extremes: every displacement is out of reach
      send_command(OP_SEARCH, 0, 0, 0, 0);
      // last atom in range, then an index beyond the count
      send_command(OP_SEARCH, 5, 0, 0, 0);
      send_command(OP_SEARCH, 63, 0, 0, 0);
      send_command(OP_SEARCH, 3, 0, 0, 0);

      // Raw displacement: the wrapped pairs fall away
      set_geometry(6, 0, 10 * ONE, 10 * ONE, 10 * ONE, 3 * ONE);
      send_command(OP_SEARCH, 1, 0, 0, 0);

      // Periodic with zero boxes: no correction applies
      set_geometry(6, 1, 0, 0, 0, 3 * ONE);
      send_command(OP_SEARCH, 1, 0, 0, 0);
      send_command(OP_SEARCH, 4, 0, 0, 0);

      // Random phases: back to back, heavy idling, light idling, heavy again
      set_geometry(16, 1, 10 * ONE, 10 * ONE, 10 * ONE, 3 * ONE);
      run_phase(30, 0, 3 * ONE);

      // Widest box and cutoff: long result bursts and wraps near the word limit
      set_geometry(64, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      run_phase(30, 66, 1 << 29);

      // Count saturates at the store size; zero boxes
      set_geometry(127, 1, 0, 0, 0, 5 * ONE);
      run_phase(30, 29, 4 * ONE);

      // Unmapped indexes must leave the register set alone
      settle();
      write_register(REG_UNMAPPED_LO, $urandom);
      write_register(REG_UNMAPPED_HI, $urandom);
      set_geometry(8, 0, 32'h7FFF_FFFF, 7 * ONE + HALF, ONE, ONE);
      run_phase(30, 66, ONE);

      settle();
      if (board.mismatches == 0 && board.outstanding() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
